[sv/dcbg_pkg.sv]
// ----------------------------------------------------------------------------
// dcbg_pkg - shared types and constants for the chirp/beep generator
// Configuration record, divider request/response, sine table and reset values.
// ----------------------------------------------------------------------------
package dcbg_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int SINE_W     = 17;
  localparam int CNT_W      = 17;
  localparam int ENV_W      = 16;

  // Divider geometry: widest dividend is a 32 x 17 bit product
  localparam int DIV_NUM_W  = 49;
  localparam int DIV_DEN_W  = 16;
  localparam int DIV_CNT_W  = 6;

  localparam logic [DIV_CNT_W-1:0] SPAN_STEPS = DIV_CNT_W'(DIV_NUM_W);
  localparam logic [DIV_CNT_W-1:0] RAMP_STEPS = DIV_CNT_W'(16);
  localparam logic [DIV_CNT_W-1:0] MOD_STEPS  = DIV_CNT_W'(32);

  localparam logic [ENV_W-1:0] FULL_SCALE = 16'h8000;
  localparam logic [15:0]      GAIN_Q15   = 16'd29490;
  localparam logic [31:0]      LCG_MUL    = 32'd1664525;
  localparam logic [31:0]      LCG_ADD    = 32'd1013904223;

  // Register indexes, at word addresses
  typedef enum logic [2:0] {
    REG_INCR_START    = 3'd0,
    REG_INCR_END      = 3'd1,
    REG_CHIRP_LENGTH  = 3'd2,
    REG_BASE_INTERVAL = 3'd3,
    REG_ATTACK_LENGTH = 3'd4,
    REG_DECAY_LENGTH  = 3'd5,
    REG_JITTER_RANGE  = 3'd6,
    REG_RNG_SEED      = 3'd7
  } reg_idx_e;

  // Register reset values
  localparam logic [31:0] RST_INCR_START    = 32'd154618822;
  localparam logic [31:0] RST_INCR_END      = 32'd223338299;
  localparam logic [15:0] RST_CHIRP_LENGTH  = 16'd3000;
  localparam logic [15:0] RST_BASE_INTERVAL = 16'd8000;
  localparam logic [11:0] RST_ATTACK_LENGTH = 12'd80;
  localparam logic [11:0] RST_DECAY_LENGTH  = 12'd120;
  localparam logic [11:0] RST_JITTER_RANGE  = 12'd200;
  localparam logic [31:0] RST_RNG_SEED      = 32'd1234567;

  typedef struct packed {
    logic [31:0] incr_start;
    logic [31:0] incr_end;
    logic [15:0] chirp_length;
    logic [15:0] base_interval;
    logic [11:0] attack_length;
    logic [11:0] decay_length;
    logic [11:0] jitter_range;
    logic [31:0] rng_seed;
  } cfg_t;

  typedef struct packed {
    logic        load;
    logic [31:0] value;
  } seed_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;   // left-aligned, steps bits used
    logic [DIV_DEN_W-1:0] divisor;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
    logic [DIV_DEN_W-1:0] remainder;
  } div_rsp_t;

  // sin(k*pi/128)*32768 towards zero, Q31 Taylor series, k in 0..64
  function automatic logic [63:0] quarter_sine(int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] m;
    if (k >= 64) begin
      return 64'd32768;
    end
    x = (64'(k) * 64'd6746518852) >> 7;
    x2 = (x * x) >> 31;
    t = 64'd2147483648;
    for (int d = 0; d < 7; d++) begin
      m = (x2 * t) >> 31;
      case (d)
        0: t = 64'd2147483648 - m / 64'd210;
        1: t = 64'd2147483648 - m / 64'd156;
        2: t = 64'd2147483648 - m / 64'd110;
        3: t = 64'd2147483648 - m / 64'd72;
        4: t = 64'd2147483648 - m / 64'd42;
        5: t = 64'd2147483648 - m / 64'd20;
        default: t = 64'd2147483648 - m / 64'd6;
      endcase
    end
    return ((x * t) >> 31) >> 16;
  endfunction

  function automatic logic [TABLE_SIZE*SINE_W-1:0] build_sine_rom();
    logic [TABLE_SIZE*SINE_W-1:0] rom;
    logic [SINE_W-1:0]            q;
    rom = '0;
    for (int k = 0; k < TABLE_SIZE / 2; k++) begin
      q = (k <= 64) ? SINE_W'(quarter_sine(k)) : SINE_W'(quarter_sine(128 - k));
      rom[k*SINE_W +: SINE_W] = q;
      rom[(k + TABLE_SIZE / 2)*SINE_W +: SINE_W] = SINE_W'(-q);
    end
    return rom;
  endfunction

  localparam logic [TABLE_SIZE*SINE_W-1:0] SINE_ROM = build_sine_rom();

  function automatic logic signed [SINE_W-1:0] sine_at(logic [7:0] idx);
    return SINE_ROM[int'(idx)*SINE_W +: SINE_W];
  endfunction

endpackage

[sv/dds_chirp_beep_generator.sv]
// ----------------------------------------------------------------------------
// dds_chirp_beep_generator - swept DDS tone bursts with envelope and jittered gaps
// Chirp word: span multiply, 49-bit divide (if count < chirp_length), envelope divide
// (none on a zero-length decay); a chirp's last sample adds an LCG step and a jitter
// divide if jitter is on. Silence skips them; one word in flight, output may stall.
// Reset: registers at defaults, chirp starts at phase 0, no clearing pass.
// ----------------------------------------------------------------------------
module dds_chirp_beep_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] sample_tick
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] pcm_sample
  output logic        m_axis_tuser,   // [0] chirp_active
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SPAN_MUL, ST_SPAN_DIV, ST_SPAN_WAIT, ST_PHASE, ST_ENV,
    ST_ENV_WAIT, ST_ENV_APPLY, ST_TONE_MUL, ST_GAIN_MUL, ST_FINISH,
    ST_LCG_MUL, ST_LCG_ADD, ST_MOD_DIV, ST_MOD_WAIT, ST_OUT
  } state_e;

  dcbg_pkg::cfg_t     cfg_s;
  dcbg_pkg::seed_t    seed_s;
  dcbg_pkg::div_req_t div_req_s;
  dcbg_pkg::div_rsp_t div_rsp_s;

  state_e                          state_q;
  logic [31:0]                     phase_q;
  logic                            in_silence_q;
  logic [dcbg_pkg::CNT_W-1:0]      count_q;
  logic [dcbg_pkg::ENV_W-1:0]      env_q;
  logic [dcbg_pkg::CNT_W-1:0]      silence_len_q;
  logic [31:0]                     lcg_q;
  logic [31:0]                     incr_q;
  logic [15:0]                     step_q;
  logic                            attack_q;
  logic [15:0]                     pcm_q;
  logic                            active_q;
  logic                            m_valid_q;
  logic [15:0]                     m_data_q;
  logic                            m_user_q;
  logic signed [65:0]              mul_p_q;

  logic                            rising_s;
  logic [31:0]                     span_s;
  logic [dcbg_pkg::CNT_W-1:0]      count_inc_s;
  logic signed [dcbg_pkg::SINE_W-1:0] tone_s;
  logic                            attack_need_s;
  logic                            decay_need_s;
  logic signed [32:0]              mul_a_s;
  logic signed [32:0]              mul_b_s;
  logic signed [16:0]              level_s;
  logic signed [65:0]              round_s;
  logic [16:0]                     env_sum_s;
  logic                            in_fire_s;

  dcbg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg_s),
    .seed_o  (seed_s)
  );

  dcbg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_s),
    .rsp_o  (div_rsp_s)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire_s     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  assign rising_s    = cfg_s.incr_end >= cfg_s.incr_start;
  assign span_s      = rising_s ? (cfg_s.incr_end - cfg_s.incr_start)
                                : (cfg_s.incr_start - cfg_s.incr_end);
  assign count_inc_s = count_q + 1'b1;
  assign tone_s      = dcbg_pkg::sine_at(phase_q[31:24]);

  assign attack_need_s = count_q < {5'd0, cfg_s.attack_length};
  assign decay_need_s  = ({1'b0, count_q} + {6'd0, cfg_s.decay_length})
                         > {2'd0, cfg_s.chirp_length};

  // floor(p / 2^15); |p| stays below 2^31 so the low bits carry the value
  assign level_s   = mul_p_q[31:15];
  assign round_s   = mul_p_q + 66'sd16384;
  assign env_sum_s = {1'b0, env_q} + {1'b0, step_q};

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      ST_SPAN_MUL: begin
        mul_a_s = {1'b0, span_s};
        mul_b_s = {16'd0, count_q};
      end
      ST_TONE_MUL: begin
        mul_a_s = {17'd0, env_q};
        mul_b_s = {{16{tone_s[dcbg_pkg::SINE_W-1]}}, tone_s};
      end
      ST_GAIN_MUL: begin
        mul_a_s = {{16{level_s[16]}}, level_s};
        mul_b_s = {17'd0, dcbg_pkg::GAIN_Q15};
      end
      ST_LCG_MUL: begin
        mul_a_s = {1'b0, lcg_q};
        mul_b_s = {1'b0, dcbg_pkg::LCG_MUL};
      end
      default: begin
        mul_a_s = '0;
        mul_b_s = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_p_q <= mul_a_s * mul_b_s;
  end

  // divider requests
  always_comb begin
    div_req_s          = '0;
    div_req_s.dividend = {dcbg_pkg::FULL_SCALE, 33'd0};
    div_req_s.steps    = dcbg_pkg::RAMP_STEPS;
    case (state_q)
      ST_SPAN_DIV: begin
        div_req_s.start    = 1'b1;
        div_req_s.dividend = mul_p_q[dcbg_pkg::DIV_NUM_W-1:0];
        div_req_s.divisor  = cfg_s.chirp_length;
        div_req_s.steps    = dcbg_pkg::SPAN_STEPS;
      end
      ST_ENV: begin
        if (attack_need_s) begin
          div_req_s.start   = 1'b1;
          div_req_s.divisor = {4'd0, cfg_s.attack_length};
        end else if (decay_need_s && (cfg_s.decay_length != '0)) begin
          div_req_s.start   = 1'b1;
          div_req_s.divisor = {4'd0, cfg_s.decay_length};
        end
      end
      ST_MOD_DIV: begin
        div_req_s.start    = 1'b1;
        div_req_s.dividend = {lcg_q, 17'd0};
        div_req_s.divisor  = {4'd0, cfg_s.jitter_range};
        div_req_s.steps    = dcbg_pkg::MOD_STEPS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= '0;
      in_silence_q  <= 1'b0;
      count_q       <= '0;
      env_q         <= '0;
      silence_len_q <= {1'b0, dcbg_pkg::RST_BASE_INTERVAL};
      lcg_q         <= dcbg_pkg::RST_RNG_SEED;
      incr_q        <= '0;
      step_q        <= '0;
      attack_q      <= 1'b0;
      pcm_q         <= '0;
      active_q      <= 1'b0;
      m_valid_q     <= 1'b0;
      m_data_q      <= '0;
      m_user_q      <= 1'b0;
    end else begin
      // ST_OUT reloads the output register itself
      if (m_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end
      if (seed_s.load) begin
        lcg_q <= seed_s.value;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire_s && s_axis_tdata[0]) begin
            if (in_silence_q) begin
              pcm_q    <= '0;
              active_q <= 1'b0;
              if (count_inc_s >= silence_len_q) begin
                in_silence_q <= 1'b0;
                count_q      <= '0;
                env_q        <= '0;
              end else begin
                count_q <= count_inc_s;
              end
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_SPAN_MUL;
            end
          end
        end
        ST_SPAN_MUL: begin
          if (count_q < {1'b0, cfg_s.chirp_length}) begin
            state_q <= ST_SPAN_DIV;
          end else begin
            incr_q  <= cfg_s.incr_end;
            state_q <= ST_PHASE;
          end
        end
        ST_SPAN_DIV: state_q <= ST_SPAN_WAIT;
        ST_SPAN_WAIT: begin
          if (div_rsp_s.done) begin
            incr_q  <= rising_s ? (cfg_s.incr_start + div_rsp_s.quotient[31:0])
                                : (cfg_s.incr_start - div_rsp_s.quotient[31:0]);
            state_q <= ST_PHASE;
          end
        end
        ST_PHASE: begin
          phase_q <= phase_q + incr_q;
          state_q <= ST_ENV;
        end
        ST_ENV: begin
          if (attack_need_s) begin
            attack_q <= 1'b1;
            state_q  <= ST_ENV_WAIT;
          end else if (decay_need_s) begin
            attack_q <= 1'b0;
            if (cfg_s.decay_length == '0) begin
              step_q  <= dcbg_pkg::FULL_SCALE;
              state_q <= ST_ENV_APPLY;
            end else begin
              state_q <= ST_ENV_WAIT;
            end
          end else begin
            state_q <= ST_TONE_MUL;
          end
        end
        ST_ENV_WAIT: begin
          if (div_rsp_s.done) begin
            step_q  <= div_rsp_s.quotient[15:0];
            state_q <= ST_ENV_APPLY;
          end
        end
        ST_ENV_APPLY: begin
          if (attack_q) begin
            env_q <= (env_sum_s > {1'b0, dcbg_pkg::FULL_SCALE}) ? dcbg_pkg::FULL_SCALE
                                                                : env_sum_s[15:0];
          end else begin
            env_q <= (env_q > step_q) ? (env_q - step_q) : '0;
          end
          state_q <= ST_TONE_MUL;
        end
        ST_TONE_MUL: state_q <= ST_GAIN_MUL;
        ST_GAIN_MUL: state_q <= ST_FINISH;
        ST_FINISH: begin
          pcm_q    <= round_s[30:15];
          active_q <= 1'b1;
          if (count_inc_s >= {1'b0, cfg_s.chirp_length}) begin
            in_silence_q <= 1'b1;
            count_q      <= '0;
            if (cfg_s.jitter_range != '0) begin
              state_q <= ST_LCG_MUL;
            end else begin
              silence_len_q <= {1'b0, cfg_s.base_interval};
              state_q       <= ST_OUT;
            end
          end else begin
            count_q <= count_inc_s;
            state_q <= ST_OUT;
          end
        end
        ST_LCG_MUL: state_q <= ST_LCG_ADD;
        ST_LCG_ADD: begin
          lcg_q   <= mul_p_q[31:0] + dcbg_pkg::LCG_ADD;
          state_q <= ST_MOD_DIV;
        end
        ST_MOD_DIV: state_q <= ST_MOD_WAIT;
        ST_MOD_WAIT: begin
          if (div_rsp_s.done) begin
            silence_len_q <= {1'b0, cfg_s.base_interval}
                             + {5'd0, div_rsp_s.remainder[11:0]};
            state_q       <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hand the word to the output register once it is free
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= pcm_q;
            m_user_q  <= active_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/dcbg_regs.sv]
// ----------------------------------------------------------------------------
// dcbg_regs - configuration register file
// APB-style slave, eight registers at word addresses, zero wait states.
// ----------------------------------------------------------------------------
module dcbg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output dcbg_pkg::cfg_t   cfg_o,
  output dcbg_pkg::seed_t  seed_o
);

  dcbg_pkg::cfg_t cfg_q;
  logic [2:0]     idx_s;
  logic           wr_s;

  assign pready = 1'b1;
  assign idx_s  = paddr[4:2];
  assign wr_s   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.incr_start    <= dcbg_pkg::RST_INCR_START;
      cfg_q.incr_end      <= dcbg_pkg::RST_INCR_END;
      cfg_q.chirp_length  <= dcbg_pkg::RST_CHIRP_LENGTH;
      cfg_q.base_interval <= dcbg_pkg::RST_BASE_INTERVAL;
      cfg_q.attack_length <= dcbg_pkg::RST_ATTACK_LENGTH;
      cfg_q.decay_length  <= dcbg_pkg::RST_DECAY_LENGTH;
      cfg_q.jitter_range  <= dcbg_pkg::RST_JITTER_RANGE;
      cfg_q.rng_seed      <= dcbg_pkg::RST_RNG_SEED;
    end else if (wr_s) begin
      case (idx_s)
        dcbg_pkg::REG_INCR_START:    cfg_q.incr_start    <= pwdata;
        dcbg_pkg::REG_INCR_END:      cfg_q.incr_end      <= pwdata;
        dcbg_pkg::REG_CHIRP_LENGTH:  cfg_q.chirp_length  <= pwdata[15:0];
        dcbg_pkg::REG_BASE_INTERVAL: cfg_q.base_interval <= pwdata[15:0];
        dcbg_pkg::REG_ATTACK_LENGTH: cfg_q.attack_length <= pwdata[11:0];
        dcbg_pkg::REG_DECAY_LENGTH:  cfg_q.decay_length  <= pwdata[11:0];
        dcbg_pkg::REG_JITTER_RANGE:  cfg_q.jitter_range  <= pwdata[11:0];
        dcbg_pkg::REG_RNG_SEED:      cfg_q.rng_seed      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx_s)
      dcbg_pkg::REG_INCR_START:    prdata = cfg_q.incr_start;
      dcbg_pkg::REG_INCR_END:      prdata = cfg_q.incr_end;
      dcbg_pkg::REG_CHIRP_LENGTH:  prdata = {16'd0, cfg_q.chirp_length};
      dcbg_pkg::REG_BASE_INTERVAL: prdata = {16'd0, cfg_q.base_interval};
      dcbg_pkg::REG_ATTACK_LENGTH: prdata = {20'd0, cfg_q.attack_length};
      dcbg_pkg::REG_DECAY_LENGTH:  prdata = {20'd0, cfg_q.decay_length};
      dcbg_pkg::REG_JITTER_RANGE:  prdata = {20'd0, cfg_q.jitter_range};
      dcbg_pkg::REG_RNG_SEED:      prdata = cfg_q.rng_seed;
      default:                     prdata = '0;
    endcase
  end

  // seed write also reloads the generator state
  assign seed_o.load  = wr_s && (idx_s == dcbg_pkg::REG_RNG_SEED);
  assign seed_o.value = pwdata;
  assign cfg_o        = cfg_q;

endmodule

[sv/dcbg_div.sv]
// ----------------------------------------------------------------------------
// dcbg_div - shared restoring divider
// One quotient bit per cycle; dividend is left-aligned, steps gives its width.
// ----------------------------------------------------------------------------
module dcbg_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dcbg_pkg::div_req_t  req_i,
  output dcbg_pkg::div_rsp_t  rsp_o
);

  logic                           busy_q;
  logic                           done_q;
  logic [dcbg_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [dcbg_pkg::DIV_NUM_W-1:0] work_q;
  logic [dcbg_pkg::DIV_DEN_W-1:0] rem_q;
  logic [dcbg_pkg::DIV_DEN_W-1:0] den_q;

  logic [dcbg_pkg::DIV_DEN_W:0]   trial_s;
  logic                           fits_s;
  logic [dcbg_pkg::DIV_DEN_W:0]   diff_s;

  assign trial_s = {rem_q, work_q[dcbg_pkg::DIV_NUM_W-1]};
  assign fits_s  = trial_s >= {1'b0, den_q};
  assign diff_s  = fits_s ? (trial_s - {1'b0, den_q}) : trial_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == dcbg_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // quotient bits shift in at the bottom as dividend bits leave the top
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      work_q <= req_i.dividend;
      rem_q  <= '0;
      den_q  <= req_i.divisor;
    end else if (busy_q) begin
      work_q <= {work_q[dcbg_pkg::DIV_NUM_W-2:0], fits_s};
      rem_q  <= diff_s[dcbg_pkg::DIV_DEN_W-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = work_q;
  assign rsp_o.remainder = rem_q;

endmodule
